// ===== src/imh_pkg.sv =====
// shared parameters and codes for the indexed max-heap
package imh_pkg;
    localparam int CAPACITY   = 256;
    localparam int VALUE_BITS = 32;

    localparam logic [1:0] REQ_INSERT  = 2'd0;
    localparam logic [1:0] REQ_ADJUST  = 2'd1;
    localparam logic [1:0] REQ_EXTRACT = 2'd2;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
    localparam logic [1:0] ERR_FULL     = 2'd2;
    localparam logic [1:0] ERR_KEY      = 2'd3;
endpackage

// ===== src/indexed_max_heap_core.sv =====
// addressable binary max-heap with key to position map
//
// One request is handled at a time: s_tready is high only while the sequencer is idle. A finished
// result waits in the output register, so the next request can be taken while the previous result
// transaction is still pending; a new result is not written until the old one has been taken.
// An insert writes the new entry at the end of the heap and sifts it up; each level up costs one
// parent read, one compare and a swap made of two writes through the single write port of each
// memory, and a sift makes at most log2(CAPACITY) swaps. An upward adjust first reads the entry
// and writes back the clipped sum. A sift down costs two child reads, a compare and the same
// two-write swap per level; an extract first reads the top and the last leaf and moves the leaf
// to the root, and a zero or negative adjust sifts down. An error or no-op request goes straight
// to the final top read and the output register. The key map holds a present bit per key in
// flip-flops, cleared at reset, so no clearing pass is needed.
module indexed_max_heap_core
    import imh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[1:0], req_key[10:2], req_value[42:11], zero fill to 48
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_value[31:0], top_key[40:32], entry_count[49:41], error_code[51:50], zero to 56
    output logic [55:0] m_tdata
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = CW;
    localparam int NK = CAPACITY + 1;
    localparam int VB = VALUE_BITS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_ADJ   = 4'd2;
    localparam logic [3:0] ST_RDA   = 4'd3;
    localparam logic [3:0] ST_CMPU  = 4'd4;
    localparam logic [3:0] ST_RDL   = 4'd5;
    localparam logic [3:0] ST_RDR   = 4'd6;
    localparam logic [3:0] ST_CMPD  = 4'd7;
    localparam logic [3:0] ST_SWA   = 4'd8;
    localparam logic [3:0] ST_SWB   = 4'd9;
    localparam logic [3:0] ST_TOP   = 4'd10;
    localparam logic [3:0] ST_TOP2  = 4'd11;
    localparam logic [3:0] ST_OUT   = 4'd12;
    localparam logic [3:0] ST_EXA   = 4'd13;
    localparam logic [3:0] ST_EXB   = 4'd14;

    logic signed [VB-1:0] prio_mem [CAPACITY];
    logic [KW-1:0]        key_mem  [CAPACITY];
    logic [AW-1:0]        pos_mem  [NK];
    logic [NK-1:0]        present_reg;

    logic [3:0]  state_reg, state_next;
    logic [CW-1:0] count_reg;
    logic [1:0]  type_reg;
    logic [KW-1:0] key_reg;
    logic signed [31:0] val_reg;
    logic [1:0]  err_reg;
    logic [AW-1:0] cur_reg;   // position being sifted
    logic [AW-1:0] oth_reg;   // partner position
    logic        down_reg;
    logic        extr_reg;
    logic signed [VB-1:0] cv_reg, ov_reg, lv_reg;
    logic [KW-1:0] ck_reg, ok_reg, lk_reg;
    logic signed [VB-1:0] rv_reg;
    logic [KW-1:0] rk_reg;
    logic          out_valid_reg;
    logic [55:0]   out_reg;

    // memory read port, data registered
    logic [AW-1:0] rd_addr;
    logic signed [VB-1:0] rd_prio;
    logic [KW-1:0] rd_key;
    logic [KW-1:0] pos_rd_key;
    logic [AW-1:0] pos_rd;

    // write ports
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [VB-1:0] wr_prio;
    logic [KW-1:0] wr_key;
    logic          pw_en;
    logic [KW-1:0] pw_key;
    logic [AW-1:0] pw_pos;

    logic [1:0]  in_type;
    logic [KW-1:0] in_key;
    logic signed [31:0] in_val;
    assign in_type = s_tdata[1:0];
    assign in_key  = KW'(s_tdata[10:2]);
    assign in_val  = s_tdata[42:11];

    localparam logic signed [VB:0] VMAX = (VB+1)'((65'sd1 <<< (VB-1)) - 65'sd1);
    localparam logic signed [VB:0] VMIN = -VMAX - (VB+1)'(1);

    function automatic logic signed [VB-1:0] sat(input logic signed [VB:0] a);
        logic signed [VB-1:0] r;
        begin
            if (a > VMAX) r = VMAX[VB-1:0];
            else if (a < VMIN) r = VMIN[VB-1:0];
            else r = a[VB-1:0];
            return r;
        end
    endfunction

    logic signed [VB+31:0] ins_wide;
    assign ins_wide = (VB+32)'(val_reg);
    logic signed [VB:0] ins_clip;
    always_comb
    begin
        if (ins_wide > (VB+32)'(VMAX)) ins_clip = VMAX;
        else if (ins_wide < (VB+32)'(VMIN)) ins_clip = VMIN;
        else ins_clip = ins_wide[VB:0];
    end

    // stored priority plus delta, clipped
    logic signed [VB+32:0] adj_sum;
    logic signed [VB:0] adj_clip;
    assign adj_sum = (VB+33)'(rd_prio) + (VB+33)'(val_reg);
    always_comb
    begin
        if (adj_sum > (VB+33)'(VMAX)) adj_clip = VMAX;
        else if (adj_sum < (VB+33)'(VMIN)) adj_clip = VMIN;
        else adj_clip = adj_sum[VB:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prio_mem[wr_addr] <= wr_prio;
            key_mem[wr_addr]  <= wr_key;
        end
        rd_prio <= prio_mem[rd_addr];
        rd_key  <= key_mem[rd_addr];
        if (pw_en) pos_mem[pw_key] <= pw_pos;
        pos_rd <= pos_mem[pos_rd_key];
    end

    logic [CW-1:0] cur_ext;
    logic [CW+1:0] lidx, ridx;
    assign cur_ext = CW'(cur_reg);
    assign lidx = (CW+2)'({cur_ext, 1'b1});
    assign ridx = lidx + 1'b1;

    logic [CW-1:0] count_next;
    logic [1:0]  err_next;
    logic [AW-1:0] cur_next, oth_next;
    logic down_next, extr_next;
    logic signed [VB-1:0] cv_next, ov_next, lv_next, rv_next;
    logic [KW-1:0] ck_next, ok_next, lk_next, rk_next;
    logic [NK-1:0] present_next;
    logic out_valid_next;
    logic [55:0] out_next;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        err_next = err_reg;
        cur_next = cur_reg;
        oth_next = oth_reg;
        down_next = down_reg;
        extr_next = extr_reg;
        cv_next = cv_reg; ov_next = ov_reg; lv_next = lv_reg; rv_next = rv_reg;
        ck_next = ck_reg; ok_next = ok_reg; lk_next = lk_reg; rk_next = rk_reg;
        present_next = present_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        rd_addr = cur_reg;
        pos_rd_key = key_reg;
        wr_en = 1'b0; wr_addr = cur_reg; wr_prio = cv_reg; wr_key = ck_reg;
        pw_en = 1'b0; pw_key = ck_reg; pw_pos = cur_reg;
        if (out_valid_reg && m_tready) out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pos_rd_key = in_key;
            end
            ST_DEC:
            begin
                err_next = ERR_OK;
                extr_next = 1'b0;
                case (type_reg)
                    REQ_INSERT:
                    begin
                        if (!(32'(key_reg) <= CAPACITY) || present_reg[key_reg])
                        begin
                            err_next = ERR_KEY; state_next = ST_TOP;
                        end
                        else if (32'(count_reg) >= CAPACITY)
                        begin
                            err_next = ERR_FULL; state_next = ST_TOP;
                        end
                        else
                        begin
                            cur_next = AW'(count_reg);
                            cv_next = sat(ins_clip);
                            ck_next = key_reg;
                            wr_en = 1'b1; wr_addr = AW'(count_reg);
                            wr_prio = sat(ins_clip); wr_key = key_reg;
                            pw_en = 1'b1; pw_key = key_reg; pw_pos = AW'(count_reg);
                            present_next[key_reg] = 1'b1;
                            count_next = count_reg + 1'b1;
                            down_next = 1'b0;
                            state_next = ST_RDA;
                            oth_next = AW'((count_reg - 1'b1) >> 1);
                        end
                    end
                    REQ_ADJUST:
                    begin
                        if (!(32'(key_reg) <= CAPACITY) || !present_reg[key_reg])
                        begin
                            err_next = ERR_KEY; state_next = ST_TOP;
                        end
                        else
                        begin
                            cur_next = pos_rd;
                            rd_addr = pos_rd;
                            state_next = ST_ADJ;
                        end
                    end
                    REQ_EXTRACT:
                    begin
                        if (count_reg == '0)
                        begin
                            err_next = ERR_UNDERFLOW; state_next = ST_TOP;
                        end
                        else
                        begin
                            rd_addr = '0;
                            cur_next = '0;
                            state_next = ST_EXA;
                        end
                    end
                    default:
                    begin
                        state_next = ST_TOP;
                    end
                endcase
            end
            ST_EXA:
            begin
                // top held in rd_prio; now read the last leaf
                rv_next = rd_prio; rk_next = rd_key;
                rd_addr = AW'(count_reg - 1'b1);
                state_next = ST_EXB;
            end
            ST_EXB:
            begin
                cv_next = rd_prio; ck_next = rd_key;
                wr_en = 1'b1; wr_addr = '0; wr_prio = rd_prio; wr_key = rd_key;
                pw_en = 1'b1; pw_key = rd_key; pw_pos = '0;
                present_next[rk_reg] = 1'b0;
                if (rk_reg == rd_key) present_next[rk_reg] = 1'b0;
                count_next = count_reg - 1'b1;
                extr_next = 1'b1;
                cur_next = '0;
                down_next = 1'b1;
                state_next = ST_RDL;
            end
            ST_ADJ:
            begin
                cv_next = sat(adj_clip);
                ck_next = rd_key;
                wr_en = 1'b1; wr_prio = sat(adj_clip); wr_key = rd_key;
                down_next = !(val_reg > 0);
                state_next = (val_reg > 0) ? ST_RDA : ST_RDL;
                oth_next = AW'((cur_ext - 1'b1) >> 1);
            end
            ST_RDA:
            begin
                // parent read for sift up
                if (cur_reg == '0) state_next = ST_TOP;
                else
                begin
                    oth_next = AW'((cur_ext - 1'b1) >> 1);
                    rd_addr = AW'((cur_ext - 1'b1) >> 1);
                    state_next = ST_CMPU;
                end
            end
            ST_CMPU:
            begin
                if (rd_prio < cv_reg)
                begin
                    ov_next = rd_prio; ok_next = rd_key;
                    state_next = ST_SWA;
                end
                else state_next = ST_TOP;
            end
            ST_RDL:
            begin
                rd_addr = AW'(lidx);
                state_next = ST_RDR;
            end
            ST_RDR:
            begin
                lv_next = rd_prio; lk_next = rd_key;
                rd_addr = AW'(ridx);
                state_next = ST_CMPD;
            end
            ST_CMPD:
            begin
                ov_next = cv_reg; ok_next = ck_reg; oth_next = cur_reg;
                if (32'(lidx) < 32'(count_reg) && lv_reg > cv_reg)
                begin
                    ov_next = lv_reg; ok_next = lk_reg; oth_next = AW'(lidx);
                    if (32'(ridx) < 32'(count_reg) && rd_prio > lv_reg)
                    begin
                        ov_next = rd_prio; ok_next = rd_key; oth_next = AW'(ridx);
                    end
                    state_next = ST_SWA;
                end
                else if (32'(ridx) < 32'(count_reg) && rd_prio > cv_reg)
                begin
                    ov_next = rd_prio; ok_next = rd_key; oth_next = AW'(ridx);
                    state_next = ST_SWA;
                end
                else state_next = ST_TOP;
            end
            ST_SWA:
            begin
                // partner entry moves into the current slot
                wr_en = 1'b1; wr_addr = cur_reg; wr_prio = ov_reg; wr_key = ok_reg;
                pw_en = 1'b1; pw_key = ok_reg; pw_pos = cur_reg;
                state_next = ST_SWB;
            end
            ST_SWB:
            begin
                wr_en = 1'b1; wr_addr = oth_reg; wr_prio = cv_reg; wr_key = ck_reg;
                pw_en = 1'b1; pw_key = ck_reg; pw_pos = oth_reg;
                cur_next = oth_reg;
                state_next = down_reg ? ST_RDL : ST_RDA;
            end
            ST_TOP:
            begin
                rd_addr = '0;
                state_next = ST_TOP2;
            end
            ST_TOP2:
            begin
                state_next = ST_OUT;
                if (!extr_reg)
                begin
                    if (count_reg != '0)
                    begin
                        rv_next = rd_prio; rk_next = rd_key;
                    end
                    else
                    begin
                        rv_next = '0; rk_next = '0;
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_next = '0;
                    out_next[31:0] = 32'(rv_reg);
                    out_next[40:32] = 9'(rk_reg);
                    out_next[49:41] = 9'(count_reg);
                    out_next[51:50] = err_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a waiting result sits in out_reg, so only the sequencer gates the input
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            present_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= (s_tvalid && s_tready) ? ST_DEC : state_next;
            count_reg <= count_next;
            present_reg <= present_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            type_reg <= in_type;
            key_reg <= in_key;
            val_reg <= in_val;
        end
        err_reg <= err_next; cur_reg <= cur_next; oth_reg <= oth_next;
        down_reg <= down_next; extr_reg <= extr_next;
        cv_reg <= cv_next; ov_reg <= ov_next; lv_reg <= lv_next; rv_reg <= rv_next;
        ck_reg <= ck_next; ok_reg <= ok_next; lk_reg <= lk_next; rk_reg <= rk_next;
        out_reg <= out_next;
    end
endmodule

// ===== src/indexed_max_heap_checker.sv =====
// port-level checks for the indexed max-heap, bound to the core module
module indexed_max_heap_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    // one request in flight: input closes right after a transaction
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready) else $error("second request accepted");

    // accepted request never answers in the next cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && (!m_tvalid || m_tready)) |=> !m_tvalid)
        else $error("result too early");

    // result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

    // an error result on an empty heap reports zero value and key
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[49:41] == 9'd0 && m_tdata[51:50] != 2'd0)
        |-> (m_tdata[40:0] == 41'd0)) else $error("empty heap top not zero");
endmodule

bind indexed_max_heap_core indexed_max_heap_checker u_checker (.*);

// ===== verif/tb_indexed_max_heap_core.sv =====
// self-checking testbench for the indexed max-heap core
module tb_indexed_max_heap_core
    import imh_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 256;
    localparam int WATCHDOG = 20000;

    // last field in the lowest bits
    typedef struct packed {
        logic [31:0] value;
        logic [8:0]  key;
        logic [1:0]  kind;
    } heap_req_t;

    typedef struct packed {
        logic [31:0] value;
        logic [8:0]  key;
        logic [8:0]  count;
        logic [1:0]  err;
    } heap_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        s_tready_seen;

    indexed_max_heap_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // predictor state
    logic signed [31:0] hp_prio [CAP];
    logic [8:0]         hp_key [CAP];
    logic [8:0]         key_pos [CAP+1];
    logic               key_held [CAP+1];
    int                 hp_fill;

    heap_req_t pending_reqs[$];
    heap_rsp_t expected_rsps[$];
    int        fail_count = 0;
    int        idle_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (s < -33'sh0_8000_0000) return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic void swap_slots(int i, int j);
        logic signed [31:0] t;
        logic [8:0] ki, kj;
        t = hp_prio[i];
        ki = hp_key[i];
        kj = hp_key[j];
        hp_prio[i] = hp_prio[j];
        hp_prio[j] = t;
        hp_key[i] = kj;
        hp_key[j] = ki;
        key_pos[kj] = 9'(i);
        key_pos[ki] = 9'(j);
    endfunction

    function automatic void bubble_up(int i);
        int p;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!(hp_prio[p] < hp_prio[i])) break;
            swap_slots(i, p);
            i = p;
        end
    endfunction

    function automatic void bubble_down(int i);
        int l, r, big;
        forever
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            big = i;
            if (l < hp_fill && hp_prio[l] > hp_prio[big]) big = l;
            if (r < hp_fill && hp_prio[r] > hp_prio[big]) big = r;
            if (big == i) break;
            swap_slots(i, big);
            i = big;
        end
    endfunction

    function automatic heap_rsp_t heap_apply(heap_req_t rq);
        heap_rsp_t rs;
        bit pulled;
        int p;
        rs = '0;
        pulled = 0;
        if (rq.kind == REQ_INSERT)
        begin
            if (rq.key > CAP || key_held[rq.key]) rs.err = ERR_KEY;
            else if (hp_fill >= CAP) rs.err = ERR_FULL;
            else
            begin
                p = hp_fill;
                hp_prio[p] = rq.value;
                hp_key[p] = rq.key;
                key_pos[rq.key] = 9'(p);
                key_held[rq.key] = 1'b1;
                hp_fill++;
                bubble_up(p);
            end
        end
        else if (rq.kind == REQ_ADJUST)
        begin
            if (rq.key > CAP || !key_held[rq.key]) rs.err = ERR_KEY;
            else
            begin
                p = key_pos[rq.key];
                hp_prio[p] = sat_sum(hp_prio[p], rq.value);
                if ($signed(rq.value) > 0) bubble_up(p);
                else bubble_down(p);
            end
        end
        else if (rq.kind == REQ_EXTRACT)
        begin
            if (hp_fill == 0) rs.err = ERR_UNDERFLOW;
            else
            begin
                rs.value = hp_prio[0];
                rs.key = hp_key[0];
                swap_slots(0, hp_fill - 1);
                hp_fill--;
                key_held[rs.key] = 1'b0;
                bubble_down(0);
                pulled = 1;
            end
        end
        if (!pulled && hp_fill > 0)
        begin
            rs.value = hp_prio[0];
            rs.key = hp_key[0];
        end
        rs.count = 9'(hp_fill);
        return rs;
    endfunction

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_tready_seen)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_tdata <= {5'd0, pending_reqs[0]};
                    s_tvalid <= 1'b1;
                    void'(pending_reqs.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s_tready_seen <= 1'b0;
        else s_tready_seen <= s_tvalid && s_tready;
    end

    // monitor
    always @(posedge clk)
    begin
        heap_rsp_t got, want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                expected_rsps.push_back(heap_apply(heap_req_t'(s_tdata[42:0])));
            if (m_tvalid && m_tready)
            begin
                got = heap_rsp_t'({m_tdata[31:0], m_tdata[40:32], m_tdata[49:41],
                                   m_tdata[51:50]});
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected result transaction %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (got.value !== want.value)
                    begin
                        $error("out_value: expected %h, got %h", want.value, got.value);
                        fail_count++;
                    end
                    if (got.key !== want.key)
                    begin
                        $error("top_key: expected %0d, got %0d", want.key, got.key);
                        fail_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.count, got.count);
                        fail_count++;
                    end
                    if (got.err !== want.err)
                    begin
                        $error("error_code: expected %0d, got %0d", want.err, got.err);
                        fail_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG)
            begin
                $display("indexed_max_heap_core test failed");
                $finish;
            end
        end
    end

    function automatic heap_req_t mk(logic [1:0] k, logic [8:0] key, logic [31:0] v);
        heap_req_t r;
        r.kind = k;
        r.key = key;
        r.value = v;
        return r;
    endfunction

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF - $urandom_range(3);
            1: return 32'h8000_0000 + $urandom_range(3);
            2: return 32'($signed($urandom_range(64)) - 32);
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_tvalid || expected_rsps.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_phase(int n, int s_pct, int r_pct, int key_span);
        int k;
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(key_span);
            case ($urandom_range(9))
                0, 1, 2: pending_reqs.push_back(mk(REQ_INSERT, 9'(k), rand_val()));
                3, 4, 5: pending_reqs.push_back(mk(REQ_ADJUST, 9'(k), rand_val()));
                6, 7: pending_reqs.push_back(mk(REQ_EXTRACT, 9'($urandom), $urandom));
                8: pending_reqs.push_back(mk(2'($urandom), 9'($urandom), $urandom));
                default: pending_reqs.push_back(mk(REQ_INSERT, 9'(k), rand_val()));
            endcase
        end
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        for (int k = 0; k <= CAP; k++)
        begin
            key_held[k] = 1'b0;
            key_pos[k] = '0;
        end
        hp_fill = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: underflow, extremes, bad keys, ties, saturation, unused type
        pending_reqs.push_back(mk(REQ_EXTRACT, 9'd0, 32'd0));
        pending_reqs.push_back(mk(REQ_ADJUST, 9'd5, 32'd1));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd256, 32'h7FFF_FFFF));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd0, 32'h8000_0000));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd0, 32'd5));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd257, 32'd5));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd511, 32'd5));
        pending_reqs.push_back(mk(REQ_ADJUST, 9'd300, 32'd5));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd7, 32'h0001_0000));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd8, 32'h0001_0000));
        pending_reqs.push_back(mk(REQ_ADJUST, 9'd256, 32'h7FFF_FFFF));
        pending_reqs.push_back(mk(REQ_ADJUST, 9'd256, 32'h7FFF_FFFF));
        pending_reqs.push_back(mk(REQ_ADJUST, 9'd0, 32'h8000_0000));
        pending_reqs.push_back(mk(REQ_ADJUST, 9'd7, 32'd0));
        pending_reqs.push_back(mk(REQ_ADJUST, 9'd256, 32'h8000_0000));
        pending_reqs.push_back(mk(2'd3, 9'h1FF, 32'hFFFF_FFFF));
        for (int i = 0; i < 5; i++)
            pending_reqs.push_back(mk(REQ_EXTRACT, 9'h1FF, 32'hFFFF_FFFF));
        wait_drained();

        // fill to capacity, overflow, then drain
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k <= CAP; k++)
            pending_reqs.push_back(mk(REQ_INSERT, 9'(k), rand_val()));
        pending_reqs.push_back(mk(REQ_INSERT, 9'd3, 32'd1));
        for (int i = 0; i < 40; i++)
            pending_reqs.push_back(mk(REQ_ADJUST, 9'($urandom_range(CAP)), rand_val()));
        for (int i = 0; i < CAP + 1; i++)
            pending_reqs.push_back(mk(REQ_EXTRACT, 9'd0, 32'd0));
        wait_drained();

        run_phase(80, 0, 0, 20);
        run_phase(80, 84, 0, 20);
        run_phase(80, 0, 84, 40);
        run_phase(80, 8, 8, 511);
        run_phase(50, 0, 0, CAP);

        repeat (50) @(posedge clk);
        if (fail_count == 0 && expected_rsps.size() == 0)
            $display("indexed_max_heap_core test passed");
        else
            $display("indexed_max_heap_core test failed");
        $finish;
    end
endmodule

// ===== indexed_max_heap_core.f =====
src/imh_pkg.sv
src/indexed_max_heap_core.sv
src/indexed_max_heap_checker.sv
verif/tb_indexed_max_heap_core.sv
